/* rtl/vtf_pkg.sv */
// Shared types, constants and helper functions for the voltage text framer.
// No dependencies; every other file in rtl/ imports this package.
package vtf_pkg;

  // Frame and field widths
  localparam int unsigned CountW = 24;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned FrameW = CountW * NumCh;
  localparam int unsigned MagW   = 24;
  localparam int unsigned ProdW  = 38;
  localparam int unsigned UnitW  = 15;

  // Scaling and CRC constants
  localparam logic [7:0]  CRC_POLY  = 8'h31;
  localparam logic [7:0]  CRC_INIT  = 8'h00;
  localparam logic [23:0] SCALE_DIV = 24'd8388607;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_PROD,
    ST_QUOT,
    ST_DIGIT,
    ST_EMIT
  } state_t;

  // Datapath conversion operations
  typedef enum logic [2:0] {
    CV_NONE,
    CV_MAG,
    CV_PROD,
    CV_QUOT,
    CV_DIGIT
  } conv_t;

  // Character slots of the output line
  typedef enum logic [4:0] {
    SL_COMMA,
    SL_V,
    SL_CHNUM,
    SL_COLON,
    SL_MINUS,
    SL_WHOLE,
    SL_POINT,
    SL_D1,
    SL_D2,
    SL_D3,
    SL_D4,
    SL_T_COMMA,
    SL_T_C1,
    SL_T_R,
    SL_T_C2,
    SL_T_COLON,
    SL_T_ZERO,
    SL_T_X,
    SL_HEX_HI,
    SL_HEX_LO,
    SL_CR,
    SL_LF
  } slot_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    conv_t      conv;
    logic [1:0] ch;
    logic [1:0] dig;
    logic       emit;
    slot_t      slot;
    logic       crc_en;
    logic       last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic neg;
  } sts_t;

  // Advance a CRC-8 (MSB first, no reflection) by one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Upper-case hex character of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

/* rtl/vtf_ctrl.sv */
// Controller of the voltage text framer: sequences the channel conversions
// and walks the character slots of the line. Depends on vtf_pkg.
module vtf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  vtf_pkg::sts_t sts,
  output vtf_pkg::cmd_t cmd
);
  import vtf_pkg::*;

  state_t     state, state_next;
  slot_t      slot, slot_next;
  logic [1:0] ch, ch_next;
  logic [1:0] dig, dig_next;

  // Hold control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= SL_V;
      ch    <= '0;
      dig   <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      ch    <= ch_next;
      dig   <= dig_next;
    end
  end

  // Next state, channel, digit step and slot
  always_comb begin
    state_next = state;
    slot_next  = slot;
    ch_next    = ch;
    dig_next   = dig;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_MAG;
          ch_next    = '0;
        end
      end
      ST_MAG:  state_next = ST_PROD;
      ST_PROD: state_next = ST_QUOT;
      ST_QUOT: begin
        state_next = ST_DIGIT;
        dig_next   = '0;
      end
      ST_DIGIT: begin
        dig_next = dig + 2'd1;
        if (dig == 2'd3) begin
          if (ch == 2'd3) begin
            state_next = ST_EMIT;
            ch_next    = '0;
            slot_next  = SL_V;
          end else begin
            state_next = ST_MAG;
            ch_next    = ch + 2'd1;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          unique case (slot)
            SL_COMMA:   slot_next = SL_V;
            SL_V:       slot_next = SL_CHNUM;
            SL_CHNUM:   slot_next = SL_COLON;
            SL_COLON:   slot_next = sts.neg ? SL_MINUS : SL_WHOLE;
            SL_MINUS:   slot_next = SL_WHOLE;
            SL_WHOLE:   slot_next = SL_POINT;
            SL_POINT:   slot_next = SL_D1;
            SL_D1:      slot_next = SL_D2;
            SL_D2:      slot_next = SL_D3;
            SL_D3:      slot_next = SL_D4;
            SL_D4: begin
              if (ch == 2'd3) begin
                slot_next = SL_T_COMMA;
              end else begin
                slot_next = SL_COMMA;
                ch_next   = ch + 2'd1;
              end
            end
            SL_T_COMMA: slot_next = SL_T_C1;
            SL_T_C1:    slot_next = SL_T_R;
            SL_T_R:     slot_next = SL_T_C2;
            SL_T_C2:    slot_next = SL_T_COLON;
            SL_T_COLON: slot_next = SL_T_ZERO;
            SL_T_ZERO:  slot_next = SL_T_X;
            SL_T_X:     slot_next = SL_HEX_HI;
            SL_HEX_HI:  slot_next = SL_HEX_LO;
            SL_HEX_LO:  slot_next = SL_CR;
            SL_CR:      slot_next = SL_LF;
            SL_LF: begin
              slot_next  = SL_V;
              state_next = ST_IDLE;
            end
            default:    slot_next = SL_V;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive commands to the datapath; refuse items while in reset
  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.conv   = CV_NONE;
    cmd.ch     = ch;
    cmd.dig    = dig;
    cmd.emit   = 1'b0;
    cmd.slot   = slot;
    cmd.crc_en = 1'b0;
    cmd.last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        cmd.load = s_tvalid && !rst;
      end
      ST_MAG:   cmd.conv = CV_MAG;
      ST_PROD:  cmd.conv = CV_PROD;
      ST_QUOT:  cmd.conv = CV_QUOT;
      ST_DIGIT: cmd.conv = CV_DIGIT;
      ST_EMIT: begin
        cmd.emit   = sts.out_free;
        cmd.crc_en = (slot <= SL_D4);
        cmd.last   = (slot == SL_LF);
      end
      default: ;
    endcase
  end

endmodule

/* rtl/vtf_dpath.sv */
// Datapath of the voltage text framer: frame registers, scaling, decimal
// digit extraction, CRC-8 and the output byte register. Depends on vtf_pkg.
module vtf_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [vtf_pkg::FrameW-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,
  output logic                        m_tlast,
  input  vtf_pkg::cmd_t               cmd,
  output vtf_pkg::sts_t               sts
);
  import vtf_pkg::*;

  logic [CountW-1:0] counts [NumCh];
  logic [NumCh-1:0]  neg;
  logic [MagW-1:0]   mag;
  logic [ProdW-1:0]  prod;
  logic [UnitW-1:0]  resid;
  logic [3:0]        whole_dig [NumCh];
  logic [3:0]        frac_dig [NumCh][4];
  logic [7:0]        crc;

  logic [CountW-1:0] counts_sel;
  logic [23:0]       qsum;
  logic [UnitW-1:0]  units;
  logic [16:0]       step_p;
  logic [16:0]       take;
  logic [3:0]        digit;
  logic [UnitW-1:0]  resid_sub;
  logic [7:0]        char_out;
  logic [1:0]        frac_idx;

  assign counts_sel = counts[cmd.ch];
  assign frac_idx   = cmd.dig - 2'd1;

  // Divide by 2^23-1: quotient is the high part plus one when high+low wraps
  always_comb begin
    qsum  = {9'h000, prod[ProdW-1:23]} + {1'b0, prod[22:0]};
    units = prod[ProdW-1:23] + UnitW'(qsum >= SCALE_DIV);
  end

  // One decimal digit per step: count how many multiples of the power fit
  always_comb begin
    unique case (cmd.dig)
      2'd0:    step_p = 17'd10000;
      2'd1:    step_p = 17'd1000;
      2'd2:    step_p = 17'd100;
      default: step_p = 17'd10;
    endcase
    digit = '0;
    take  = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, resid} >= 17'(k) * step_p) begin
        digit = 4'(k);
        take  = 17'(k) * step_p;
      end
    end
    resid_sub = UnitW'({2'b00, resid} - take);
  end

  // Capture the frame and run the conversion steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < NumCh; c++) begin
        counts[c] <= s_tdata[c*CountW +: CountW];
      end
    end
    unique case (cmd.conv)
      CV_MAG: begin
        neg[cmd.ch] <= counts_sel[CountW-1];
        mag         <= counts_sel[CountW-1] ? (~counts_sel + 24'd1) : counts_sel;
      end
      CV_PROD:  prod  <= ({14'h0000, mag} << 14) + ({14'h0000, mag} << 12);
      CV_QUOT:  resid <= units;
      CV_DIGIT: begin
        resid <= resid_sub;
        if (cmd.dig == 2'd0) begin
          whole_dig[cmd.ch] <= digit;
        end else begin
          frac_dig[cmd.ch][frac_idx] <= digit;
        end
        if (cmd.dig == 2'd3) begin
          frac_dig[cmd.ch][3] <= resid_sub[3:0];
        end
      end
      default: ;
    endcase
  end

  // Select the character of the current slot
  always_comb begin
    unique case (cmd.slot) inside
      SL_COMMA, SL_T_COMMA: char_out = 8'h2C;
      SL_V:                 char_out = 8'h56;
      SL_CHNUM:             char_out = 8'h31 + {6'h00, cmd.ch};
      SL_COLON, SL_T_COLON: char_out = 8'h3A;
      SL_MINUS:             char_out = 8'h2D;
      SL_WHOLE:             char_out = 8'h30 + {4'h0, whole_dig[cmd.ch]};
      SL_POINT:             char_out = 8'h2E;
      SL_D1:                char_out = 8'h30 + {4'h0, frac_dig[cmd.ch][0]};
      SL_D2:                char_out = 8'h30 + {4'h0, frac_dig[cmd.ch][1]};
      SL_D3:                char_out = 8'h30 + {4'h0, frac_dig[cmd.ch][2]};
      SL_D4:                char_out = 8'h30 + {4'h0, frac_dig[cmd.ch][3]};
      SL_T_C1, SL_T_C2:     char_out = 8'h43;
      SL_T_R:               char_out = 8'h52;
      SL_T_ZERO:            char_out = 8'h30;
      SL_T_X:               char_out = 8'h78;
      SL_HEX_HI:            char_out = hex_char(crc[7:4]);
      SL_HEX_LO:            char_out = hex_char(crc[3:0]);
      SL_CR:                char_out = 8'h0D;
      SL_LF:                char_out = 8'h0A;
      default:              char_out = 8'h00;
    endcase
  end

  // Clear the CRC per frame and advance it over the text bytes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      crc <= CRC_INIT;
    end else if (cmd.emit && cmd.crc_en) begin
      crc <= crc8_byte(crc, char_out);
    end
  end

  // Output item register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= char_out;
      m_tlast <= cmd.last;
    end
  end

  assign sts.out_free = !m_tvalid || m_tready;
  assign sts.neg      = neg[cmd.ch];

endmodule

/* rtl/voltage_text_framer_crc8_top.sv */
// Takes a frame of four signed 24-bit ADC counts and streams out the ASCII
// line "V1:x.xxxx,V2:..,V3:..,V4:..,CRC:0xHH" followed by CR LF, one byte per
// output item, with tlast on the LF. Each channel is scaled to 100-microvolt
// units as floor(|counts| * 20480 / 8388607) and printed with a leading '-'
// when the raw count is negative (so small negatives read -0.0000). The CRC-8
// (polynomial 0x31, initial 0, MSB first) covers the text before ",CRC". A
// frame is accepted only while the block is idle; it then converts with
// seven steps per channel through one shared scaling and digit unit, and
// sends the line (50 to 54 bytes) through a single output register, one
// byte per cycle when the sink never stalls. The output register lets the
// last byte wait while the next frame is taken. Depends on vtf_pkg, vtf_ctrl
// and vtf_dpath.
module voltage_text_framer_crc8_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // channel_one_counts [23:0], channel_two_counts [47:24],
  // channel_three_counts [71:48], channel_four_counts [95:72]
  input  logic [vtf_pkg::FrameW-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // text_byte [7:0]
  output logic [7:0]                  m_tdata,
  // last_byte
  output logic                        m_tlast
);
  import vtf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vtf_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

/* test/voltage_text_framer_crc8_top_tb.sv */
// Self-checking testbench for voltage_text_framer_crc8_top: sends frames of four ADC
// counts and checks every byte of the telemetry line against a built-in line formatter.
// Depends on vtf_pkg and the RTL under rtl/.
module voltage_text_framer_crc8_top_tb;

  localparam int          ResetCycles = 9;
  localparam int          QuietLimit  = 5000;
  localparam int          DrainCycles = 100;
  localparam int          SearchTries = 2000;
  localparam logic [23:0] CountMax    = 24'h7FFFFF;
  localparam logic [23:0] CountMin    = 24'h800000;
  localparam logic [63:0] ScaleMul    = 64'd20480;
  localparam logic [63:0] ScaleDiv    = 64'd8388607;
  localparam logic [63:0] DecBase     = 64'd10000;
  localparam logic [7:0]  CrcPoly     = 8'h31;
  localparam logic [7:0]  CharCr      = 8'h0D;
  localparam logic [7:0]  CharLf      = 8'h0A;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } line_byte_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  // channel_one_counts, channel_two_counts, channel_three_counts, channel_four_counts
  logic [vtf_pkg::FrameW-1:0] s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  // text_byte
  logic [7:0]                 m_tdata;
  // last_byte
  logic                       m_tlast;

  logic [7:0] line_chars[$];
  line_byte_t expected_bytes[$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         mismatches;
  int         frames_sent;
  int         low_crc_frames;
  int         bytes_checked;
  int         quiet_cycles;

  voltage_text_framer_crc8_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Append one decimal digit character
  function automatic void push_digit(input logic [63:0] value);
    line_chars.push_back(8'h30 + value[7:0]);
  endfunction

  // Upper-case hex character of one nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h41 + {4'h0, nib} - 8'd10;
    end
    return c;
  endfunction

  // Build the whole telemetry line for one frame into line_chars; return its CRC-8
  function automatic logic [7:0] build_line(input logic [vtf_pkg::FrameW-1:0] frame);
    logic [23:0] counts;
    logic [63:0] mag;
    logic [63:0] units;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [7:0]  crc;
    logic [7:0]  ch_char;
    logic [7:0]  data;
    logic        feedback;
    string       tail;
    tail = ",CRC:0x";
    line_chars.delete();
    for (int ch = 0; ch < 4; ch++) begin
      counts = frame[ch*24 +: 24];
      if (ch != 0) begin
        line_chars.push_back(",");
      end
      ch_char = "1";
      ch_char = ch_char + ch[7:0];
      line_chars.push_back("V");
      line_chars.push_back(ch_char);
      line_chars.push_back(":");
      // Sign follows the raw count; the most negative count keeps magnitude 2^23
      mag   = {40'd0, counts[23] ? (~counts + 24'd1) : counts};
      units = (mag * ScaleMul) / ScaleDiv;
      whole = units / DecBase;
      frac  = units % DecBase;
      if (counts[23]) begin
        line_chars.push_back("-");
      end
      push_digit(whole % 10);
      line_chars.push_back(".");
      push_digit((frac / 1000) % 10);
      push_digit((frac / 100) % 10);
      push_digit((frac / 10) % 10);
      push_digit(frac % 10);
    end
    // CRC over the text so far, one bit at a time, MSB first
    crc = 8'h00;
    for (int i = 0; i < line_chars.size(); i++) begin
      data = line_chars[i];
      for (int b = 7; b >= 0; b--) begin
        feedback = crc[7] ^ data[b];
        crc      = {crc[6:0], 1'b0} ^ (feedback ? CrcPoly : 8'h00);
      end
    end
    for (int i = 0; i < tail.len(); i++) begin
      line_chars.push_back(tail[i]);
    end
    line_chars.push_back(nibble_char(crc[7:4]));
    line_chars.push_back(nibble_char(crc[3:0]));
    line_chars.push_back(CharCr);
    line_chars.push_back(CharLf);
    return crc;
  endfunction

  // Random channel count: half full range, the rest small values and extremes
  function automatic logic [23:0] pick_counts();
    logic [23:0] v;
    case ($urandom_range(5))
      0: begin
        v = 24'($urandom_range(5000));
      end
      1: begin
        v = 24'($urandom_range(5000));
        v = -v;
      end
      2: begin
        case ($urandom_range(3))
          0: v = CountMax;
          1: v = CountMin;
          2: v = 24'h000000;
          default: v = 24'hFFFFFF;
        endcase
      end
      default: begin
        v = 24'($urandom);
      end
    endcase
    return v;
  endfunction

  // Send one frame, idling first as the current mode asks; queue its line on acceptance
  task automatic send_frame(input logic [23:0] c1, input logic [23:0] c2,
                            input logic [23:0] c3, input logic [23:0] c4);
    logic [7:0] crc;
    line_byte_t entry;
    int         gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c4, c3, c2, c1};
    do @(posedge clk); while (!s_tready);
    crc = build_line({c4, c3, c2, c1});
    for (int i = 0; i < line_chars.size(); i++) begin
      entry.text_byte = line_chars[i];
      entry.last_byte = (i == line_chars.size() - 1);
      expected_bytes.push_back(entry);
    end
    frames_sent++;
    if (crc < 8'h10) begin
      low_crc_frames++;
    end
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Full-scale, zero and -1 counts, rotated through every channel position
  task automatic test_extremes();
    send_frame(CountMax, CountMax, CountMax, CountMax);
    send_frame(CountMin, CountMin, CountMin, CountMin);
    send_frame(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_frame(CountMax, CountMin, 24'h000000, 24'hFFFFFF);
    send_frame(CountMin, 24'h000000, 24'hFFFFFF, CountMax);
    send_frame(24'h000000, 24'hFFFFFF, CountMax, CountMin);
    send_frame(24'hFFFFFF, CountMax, CountMin, 24'h000000);
  endtask

  // Small negatives, rounding edges near the last digit and near one volt
  task automatic test_small_values();
    send_frame(-24'd1, -24'd409, -24'd410, 24'd0);
    send_frame(24'd409, 24'd410, 24'd1, 24'd4096);
    send_frame(24'd4095999, 24'd4096000, -24'd4095999, -24'd4096000);
    send_frame(24'd4097, -24'd4097, 24'd8388606, -24'd8388607);
    send_frame(24'd1000, 24'd200000, 24'h400000, -24'd1234567);
  endtask

  // Find frames whose CRC needs a leading zero or two letter digits
  task automatic test_crc_corners();
    logic [23:0] c[4];
    logic [7:0]  crc;
    for (int want_low = 0; want_low < 2; want_low++) begin
      for (int t = 0; t < SearchTries; t++) begin
        for (int k = 0; k < 4; k++) begin
          c[k] = pick_counts();
        end
        crc = build_line({c[3], c[2], c[1], c[0]});
        if ((want_low == 0 && crc < 8'h10) ||
            (want_low == 1 && crc[7:4] >= 4'hA && crc[3:0] >= 4'hA)) begin
          break;
        end
      end
      send_frame(c[0], c[1], c[2], c[3]);
    end
  endtask

  // Random frames; optionally hold the sender halfway until every byte has come out
  task automatic test_random_frames(input int count, input bit pause_midway);
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) begin
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
      end
      send_frame(pick_counts(), pick_counts(), pick_counts(), pick_counts());
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output item with the oldest expected byte
  always @(posedge clk) begin : check_output
    line_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output item: text_byte %h last_byte %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.text_byte) begin
          $error("text_byte mismatch: expected %h, actual %h", want.text_byte, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.last_byte) begin
          $error("last_byte mismatch: expected %b, actual %b", want.last_byte, m_tlast);
          mismatches++;
        end
        bytes_checked++;
      end
    end
  end

  // Abort when neither side has moved an item for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    m_tready       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    frames_sent    = 0;
    low_crc_frames = 0;
    bytes_checked  = 0;
    quiet_cycles   = 0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    test_extremes();
    test_small_values();
    test_crc_corners();
    test_random_frames(42, 1'b0);
    set_idling(81, 0);
    test_random_frames(42, 1'b1);
    set_idling(0, 81);
    test_random_frames(42, 1'b0);
    set_idling(21, 21);
    test_random_frames(42, 1'b0);

    // Drain the remaining lines, then watch for stray output
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d frames (%0d with a CRC below 0x10) and checked %0d bytes,",
             frames_sent, low_crc_frames, bytes_checked);
    $display("with no idling, sender gaps, receiver stalls and both mixed.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/vtf_pkg.sv
rtl/vtf_ctrl.sv
rtl/vtf_dpath.sv
rtl/voltage_text_framer_crc8_top.sv
test/voltage_text_framer_crc8_top_tb.sv
